// ===== src/swm_pkg.sv =====
// Shared types and constants of the sliding window maximum block.
package swm_pkg;

    localparam int SAMPLE_W    = 32;
    localparam int WIN_W       = 7;
    localparam int GROUP_CELLS = 8;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    // One candidate cell as seen by its older neighbor and by the selection tree
    typedef struct packed {
        logic    alive;
        sample_t value;
    } cell_t;

    // Per-transaction control broadcast to every cell
    typedef struct packed {
        logic    shift;
        logic    clear;
        sample_t sample;
    } step_t;

endpackage

// ===== src/swm_if.sv =====
// Stream interfaces for the sample input and the maximum output.
interface swm_in_if import swm_pkg::*;;
    logic    valid;
    logic    ready;
    sample_t sample;
    logic    end_of_sequence;

    modport source (output valid, output sample, output end_of_sequence, input ready);
    modport sink   (input valid, input sample, input end_of_sequence, output ready);
endinterface

interface swm_out_if import swm_pkg::*;;
    logic    valid;
    logic    ready;
    sample_t window_max;
    logic    end_of_sequence_res;

    modport source (output valid, output window_max, output end_of_sequence_res, input ready);
    modport sink   (input valid, input window_max, input end_of_sequence_res, output ready);
endinterface

// ===== src/swm_cell.sv =====
// One candidate cell: holds the sample of a fixed age and its survival flag.
module swm_cell import swm_pkg::*;
#(
    parameter int POS = 0,
    parameter int CW  = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  step_t         step,
    input  logic [CW-1:0] win,
    input  cell_t         prev,
    output cell_t         cur
);

    logic    alive_reg;
    logic    alive_next;
    logic    survives;
    sample_t value_reg;

    // Drop a candidate that falls out of the window, is beaten by the new
    // sample, or belongs to a finished sequence
    always_comb
    begin
        survives   = (POS == 0) || (!step.clear && !(prev.value < step.sample));
        alive_next = prev.alive && survives && (CW'(POS) < win);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alive_reg <= 1'b0;
        end
        else if (step.shift)
        begin
            alive_reg <= alive_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.shift)
        begin
            value_reg <= prev.value;
        end
    end

    assign cur = '{alive: alive_reg, value: value_reg};

endmodule

// ===== src/swm_group.sv =====
// Registered pick of the oldest live cell within one group of cells.
module swm_group import swm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  en,
    input  cell_t cells [GROUP_CELLS],
    output cell_t pick
);

    logic    found_reg;
    logic    found_next;
    sample_t value_reg;
    sample_t value_next;

    // Higher index is older; the last live cell in the scan wins
    always_comb
    begin
        found_next = 1'b0;
        value_next = cells[0].value;
        for (int i = 0; i < GROUP_CELLS; i++)
        begin
            if (cells[i].alive)
            begin
                found_next = 1'b1;
                value_next = cells[i].value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (en)
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
        end
    end

    assign pick = '{alive: found_reg, value: value_reg};

endmodule

// ===== src/sliding_window_maximum_core.sv =====
// Sliding window maximum: a row of WINDOW_MAX shifting cells, one per sample age, keeps
// the monotonic candidate set; every accepted transaction shifts the whole row at once,
// so one sample is taken per cycle while the result side keeps up. After the row, the
// result passes through the registered per-group pick of the oldest live cell (groups
// of eight) and then the pick across groups into the output register. A stalled output
// register holds the whole row, and no sample is taken until it drains. An
// end-of-sequence marker empties the cells when the next sample arrives. window_size
// outside 1..WINDOW_MAX is treated as the nearest bound.
module sliding_window_maximum_core import swm_pkg::*;
#(
    parameter int WINDOW_MAX = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [WIN_W-1:0]    cfg_wdata,
    swm_in_if.sink              stream,
    swm_out_if.source           result
);

    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int CW     = (FILL_W > WIN_W) ? FILL_W : WIN_W;
    localparam int NG     = (WINDOW_MAX + GROUP_CELLS - 1) / GROUP_CELLS;

    logic [WIN_W-1:0] win_reg;
    logic [CW-1:0]    win_ext;
    logic [CW-1:0]    win_eff;
    logic [CW-1:0]    filled_reg;
    logic [CW-1:0]    filled_next;
    logic [CW-1:0]    fill_base;
    logic             seq_end_reg;
    logic             stall;
    logic             accept;
    logic             emit;
    step_t            step;

    logic             p0_valid_reg;
    logic             p0_eos_reg;
    logic             p1_valid_reg;
    logic             p1_eos_reg;
    logic             out_valid_reg;
    logic             out_eos_reg;
    sample_t          out_max_reg;
    sample_t          max_next;

    cell_t            prev  [WINDOW_MAX];
    cell_t            cells [WINDOW_MAX];
    cell_t            pad   [NG*GROUP_CELLS];
    cell_t            grp_pick [NG];

    assign stall        = out_valid_reg && !result.ready;
    assign stream.ready = !stall;
    assign accept       = stream.valid && !stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= WIN_W'(1);
        end
        else if (cfg_we)
        begin
            win_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        win_ext = CW'(win_reg);
        priority if (win_ext == '0)
        begin
            win_eff = CW'(1);
        end
        else if (win_ext > CW'(WINDOW_MAX))
        begin
            win_eff = CW'(WINDOW_MAX);
        end
        else
        begin
            win_eff = win_ext;
        end
    end

    // Restart the count after an end marker; saturate at the row length
    always_comb
    begin
        fill_base   = seq_end_reg ? '0 : filled_reg;
        filled_next = (fill_base == CW'(WINDOW_MAX)) ? fill_base : fill_base + CW'(1);
        emit        = filled_next >= win_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg  <= '0;
            seq_end_reg <= 1'b0;
        end
        else if (accept)
        begin
            filled_reg  <= filled_next;
            seq_end_reg <= stream.end_of_sequence;
        end
    end

    assign step = '{shift: accept, clear: seq_end_reg, sample: stream.sample};

    for (genvar k = 0; k < WINDOW_MAX; k++)
    begin : g_cell
        if (k == 0)
        begin : g_head
            assign prev[k] = '{alive: 1'b1, value: stream.sample};
        end
        else
        begin : g_link
            assign prev[k] = cells[k-1];
        end

        swm_cell #(
            .POS (k),
            .CW  (CW)
        ) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .step  (step),
            .win   (win_eff),
            .prev  (prev[k]),
            .cur   (cells[k])
        );
    end

    for (genvar k = 0; k < NG*GROUP_CELLS; k++)
    begin : g_pad
        if (k < WINDOW_MAX)
        begin : g_real
            assign pad[k] = cells[k];
        end
        else
        begin : g_empty
            assign pad[k] = '{alive: 1'b0, value: '0};
        end
    end

    for (genvar g = 0; g < NG; g++)
    begin : g_grp
        cell_t grp_cells [GROUP_CELLS];

        for (genvar j = 0; j < GROUP_CELLS; j++)
        begin : g_member
            assign grp_cells[j] = pad[g*GROUP_CELLS + j];
        end

        swm_group u_group (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (!stall),
            .cells (grp_cells),
            .pick  (grp_pick[g])
        );
    end

    // Oldest live group holds the maximum
    always_comb
    begin
        max_next = grp_pick[0].value;
        for (int g = 0; g < NG; g++)
        begin
            if (grp_pick[g].alive)
            begin
                max_next = grp_pick[g].value;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (!stall)
        begin
            p0_valid_reg  <= accept && emit;
            p1_valid_reg  <= p0_valid_reg;
            out_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!stall)
        begin
            p0_eos_reg  <= stream.end_of_sequence;
            p1_eos_reg  <= p0_eos_reg;
            out_eos_reg <= p1_eos_reg;
            out_max_reg <= max_next;
        end
    end

    assign result.valid               = out_valid_reg;
    assign result.window_max          = out_max_reg;
    assign result.end_of_sequence_res = out_eos_reg;

endmodule

// ===== src/swm_checker.sv =====
// Port-level checks for the sliding window maximum block and their binding.
module swm_checker import swm_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input sample_t out_max,
    input logic    out_eos
);

    // A result not taken stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_max) && $stable(out_eos))
        else $error("result payload changed while stalled");

    // Input side is held off only by a stalled result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input held off without an output stall");

    // Nothing is offered right after reset is released
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

endmodule

bind sliding_window_maximum_core swm_checker u_swm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (stream.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_max   (result.window_max),
    .out_eos   (result.end_of_sequence_res)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of sliding_window_maximum_core with its own window maximum predictor.
module testbench;
    import swm_pkg::*;

    localparam int WINDOW_DEPTH  = 64;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 12;
    localparam int STALL_LIMIT   = 1000;
    localparam int LONG_HOLD     = 150;

    typedef struct {
        sample_t     value;
        int unsigned age;
    } candidate_t;

    typedef struct {
        sample_t window_max;
        logic    last;
    } maximum_t;

    typedef enum int {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_RISING,
        FILL_FALLING,
        FILL_EXTREME
    } fill_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [WIN_W-1:0] cfg_wdata;

    swm_in_if  stream_if();
    swm_out_if result_if();

    sliding_window_maximum_core #(.WINDOW_MAX(WINDOW_DEPTH)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stream    (stream_if),
        .result    (result_if)
    );

    // Predictor state: candidate cells oldest first, samples in the sequence, window register
    candidate_t       candidates[$];
    int unsigned      seen_in_sequence;
    logic [WIN_W-1:0] window_reg;
    maximum_t         maxima_due[$];

    int          error_count = 0;
    int          quiet_cycles = 0;
    bit          tx_idle_on;
    bit          rx_idle_on;
    int unsigned hold_request;
    maximum_t    due;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void predict_window_max(input sample_t s, input logic last);
        int unsigned w;
        maximum_t    m;
        candidate_t  c;
        w = 32'(window_reg);
        if (w < 1)
            w = 1;
        if (w > WINDOW_DEPTH)
            w = WINDOW_DEPTH;
        foreach (candidates[i])
            candidates[i].age++;
        // drop cells leaving the window, then strictly smaller ones from the new end
        while (candidates.size() > 0 && candidates[0].age >= w)
            candidates.delete(0);
        while (candidates.size() > 0 && candidates[$].value < s)
            candidates.delete(candidates.size() - 1);
        c.value = s;
        c.age   = 0;
        candidates.insert(candidates.size(), c);
        if (seen_in_sequence < WINDOW_DEPTH)
            seen_in_sequence++;
        if (seen_in_sequence >= w)
        begin
            m.window_max = candidates[0].value;
            m.last       = last;
            maxima_due.insert(maxima_due.size(), m);
        end
        if (last)
        begin
            candidates.delete();
            seen_in_sequence = 0;
        end
    endfunction

    // Leaves valid high on return so that a following item goes out back to back
    task automatic offer_sample(input sample_t s, input logic last);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 5) == 0)
            gap = $urandom_range(1, 13);
        if (gap > 0)
        begin
            stream_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_if.valid           <= 1'b1;
        stream_if.sample          <= s;
        stream_if.end_of_sequence <= last;
        do
            @(posedge clk);
        while (!stream_if.ready);
        predict_window_max(s, last);
    endtask

    task automatic set_window(input logic [WIN_W-1:0] w);
        stream_if.valid <= 1'b0;
        while (maxima_due.size() != 0)
            @(posedge clk);
        // items that give no result may still be in flight
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we     <= 1'b0;
        window_reg = w;
    endtask

    task automatic run_random_streams(input int n_items, input int max_len);
        int      sent;
        int      len;
        int      step;
        fill_t   fill;
        sample_t base;
        sample_t s;
        sent = 0;
        while (sent < n_items)
        begin
            len  = $urandom_range(1, max_len);
            fill = fill_t'($urandom_range(0, 4));
            base = $urandom;
            step = $urandom_range(1, 1000);
            for (int k = 0; k < len && sent < n_items; k++)
            begin
                case (fill)
                    FILL_NARROW:  s = $signed($urandom_range(0, 6)) - 3;
                    FILL_RISING:  s = base + k * step;
                    FILL_FALLING: s = base - k * step;
                    FILL_EXTREME:
                        case ($urandom_range(0, 3))
                            0:       s = 32'sh8000_0000;
                            1:       s = 32'sh7FFF_FFFF;
                            2:       s = -1;
                            default: s = 0;
                        endcase
                    default:      s = $urandom;
                endcase
                offer_sample(s, k == len - 1);
                sent++;
            end
        end
    endtask

    task automatic test_reset_window();
        offer_sample(32'sh8000_0000, 1'b0);
        offer_sample(32'sh7FFF_FFFF, 1'b0);
        offer_sample(-1, 1'b0);
        offer_sample(0, 1'b0);
        offer_sample(1, 1'b1);
    endtask

    task automatic test_window_bounds();
        // zero acts as one, anything above the depth acts as the depth
        set_window(0);
        offer_sample(10, 1'b0);
        offer_sample(-10, 1'b1);
        set_window(127);
        offer_sample(32'sh7FFF_FFFF, 1'b0);
        offer_sample(5, 1'b0);
        offer_sample(32'sh8000_0000, 1'b1);
    endtask

    task automatic test_equal_values();
        set_window(3);
        offer_sample(5, 1'b0);
        offer_sample(5, 1'b0);
        offer_sample(5, 1'b0);
        offer_sample(4, 1'b0);
        offer_sample(5, 1'b0);
        offer_sample(5, 1'b1);
    endtask

    task automatic test_window_change();
        set_window(4);
        offer_sample(9, 1'b0);
        offer_sample(8, 1'b0);
        offer_sample(7, 1'b0);
        offer_sample(6, 1'b0);
        // shrink drops old cells at once, growing does not bring them back
        set_window(2);
        offer_sample(5, 1'b0);
        offer_sample(1, 1'b0);
        set_window(6);
        offer_sample(2, 1'b0);
        offer_sample(3, 1'b1);
    endtask

    task automatic test_random_streams();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        set_window(2);
        run_random_streams(40, 8);
        set_window(64);
        run_random_streams(150, 140);
        tx_idle_on = 1'b0;
        set_window(5);
        run_random_streams(50, 15);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b0;
        set_window(1);
        run_random_streams(30, 6);
        rx_idle_on = 1'b1;
        set_window(100);
        run_random_streams(70, 100);
        set_window(WIN_W'($urandom_range(3, 16)));
        run_random_streams(60, 40);
    endtask

    task automatic test_output_stall();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_window(3);
        hold_request = LONG_HOLD;
        run_random_streams(50, 12);
    endtask

    task automatic test_steady_stream();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        set_window(WIN_W'($urandom_range(1, 8)));
        run_random_streams(60, 20);
    endtask

    // Result side: random stall bursts, plus one long hold on request
    initial
    begin
        int n;
        result_if.ready = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_request > 0)
            begin
                n            = hold_request;
                hold_request = 0;
                result_if.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                result_if.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_if.valid === 1'b1 && result_if.ready === 1'b1)
        begin
            if (maxima_due.size() == 0)
            begin
                $display("%0t: unexpected result window_max=%0d end_of_sequence_res=%0b",
                         $time, result_if.window_max, result_if.end_of_sequence_res);
                error_count++;
            end
            else
            begin
                due = maxima_due[0];
                maxima_due.delete(0);
                if (result_if.window_max !== due.window_max)
                begin
                    $display("%0t: window_max expected %0d actual %0d",
                             $time, due.window_max, result_if.window_max);
                    error_count++;
                end
                if (result_if.end_of_sequence_res !== due.last)
                begin
                    $display("%0t: end_of_sequence_res expected %0b actual %0b",
                             $time, due.last, result_if.end_of_sequence_res);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((stream_if.valid === 1'b1 && stream_if.ready === 1'b1) ||
            (result_if.valid === 1'b1 && result_if.ready === 1'b1))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n                     = 1'b0;
        cfg_we                    = 1'b0;
        cfg_wdata                 = '0;
        stream_if.valid           = 1'b0;
        stream_if.sample          = '0;
        stream_if.end_of_sequence = 1'b0;
        window_reg                = 1;
        seen_in_sequence          = 0;
        tx_idle_on                = 1'b0;
        rx_idle_on                = 1'b0;
        hold_request              = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_window();
        test_window_bounds();
        test_equal_values();
        test_window_change();
        test_random_streams();
        test_output_stall();
        test_steady_stream();

        stream_if.valid <= 1'b0;
        while (maxima_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
